/* hdl/edrt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edrt_pkg
// shared constants and types of the deferred release tracker
// ----------------------------------------------------------------------------
package edrt_pkg;
   localparam int TableDepthDefault  = 32;
   localparam int WorkerLimitDefault = 8;
   localparam int GenBitsDefault     = 32;

   localparam logic [1:0] OP_RETIRE = 2'd0;
   localparam logic [1:0] OP_SWEEP  = 2'd1;
   localparam logic [1:0] OP_SETGEN = 2'd2;
   localparam logic [1:0] OP_DRAIN  = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] handle;
      logic [7:0]  release_kind;
      logic [2:0]  worker_index;
      logic [31:0] generation;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        released_valid;
      logic [31:0] released_handle;
      logic [7:0]  released_kind;
      logic [5:0]  reclaimed_count;
      logic        last;
   } rsp_type;
endpackage

/* hdl/edrt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edrt_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface edrt_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* hdl/edrt_safe_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edrt_safe_check
// compares one snapshot word per cycle against current generations
// ----------------------------------------------------------------------------
module edrt_safe_check
   import edrt_pkg::*;
#(
   parameter int GEN_BITS = GenBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                snap_valid,
   input  logic                snap_last,
   input  logic [GEN_BITS-1:0] snap_value,
   input  logic [GEN_BITS-1:0] cur_value,
   output logic                done,
   output logic                safe
);
   logic hit_ff, hit_in;
   logic done_ff, done_in;

   always_comb begin
      hit_in  = start ? 1'b0 : hit_ff;
      done_in = 1'b0;
      if (snap_valid) begin
         if (snap_value == cur_value) hit_in = 1'b1;
         done_in = snap_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         hit_ff  <= hit_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign safe = !hit_ff;
endmodule

/* hdl/epoch_deferred_release_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_deferred_release_tracker
// epoch based deferred release table
// ----------------------------------------------------------------------------
// One transaction is worked at a time. An accepted retire writes its
// snapshot one worker per cycle into the snapshot memory. A sweep reads,
// for each pending entry, its snapshot words one per cycle from the
// single-port snapshot memory, as many as the effective worker count, and
// then keeps or releases the entry. Results leave through a one-deep
// output register; a sweep or drain keeps its newest release one step back
// so that the count and last flag can be put on it. A stalled result side
// holds up the transaction.
// ----------------------------------------------------------------------------
module epoch_deferred_release_tracker
   import edrt_pkg::*;
#(
   parameter int TABLE_DEPTH  = TableDepthDefault,
   parameter int WORKER_LIMIT = WorkerLimitDefault,
   parameter int GEN_BITS     = GenBitsDefault
) (
   input logic        clock,
   input logic        reset,
   edrt_if.sink       req,
   edrt_if.source     rsp,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_data
);
   localparam int SW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int WW = (WORKER_LIMIT > 1) ? $clog2(WORKER_LIMIT) : 1;
   localparam int WCW = $clog2(WORKER_LIMIT + 1);
   localparam int AW = $clog2(TABLE_DEPTH * WORKER_LIMIT);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SNAP  = 4'd1;   // write snapshot words
   localparam logic [3:0] S_OUT   = 4'd2;   // wait for output register free
   localparam logic [3:0] S_SRD   = 4'd3;   // sweep: read order entry
   localparam logic [3:0] S_SLOT  = 4'd4;   // load slot from order entry
   localparam logic [3:0] S_SCMP  = 4'd5;   // sweep: stream snapshot words
   localparam logic [3:0] S_SWAIT = 4'd6;   // sweep: wait for compare result
   localparam logic [3:0] S_SDEC  = 4'd7;   // sweep: release or keep
   localparam logic [3:0] S_DRD   = 4'd8;   // drain: read order entry
   localparam logic [3:0] S_DREL  = 4'd9;   // drain/sweep: read handle memory
   localparam logic [3:0] S_DEMIT = 4'd10;  // emit released entry
   localparam logic [3:0] S_FIN   = 4'd11;  // final count result

   // memories
   logic [31:0]         handle_mem [TABLE_DEPTH];
   logic [7:0]          kind_mem   [TABLE_DEPTH];
   logic [SW-1:0]       order_mem  [TABLE_DEPTH];
   logic [GEN_BITS-1:0] snap_mem   [TABLE_DEPTH*WORKER_LIMIT];

   logic [TABLE_DEPTH-1:0]  in_use_ff, in_use_in;
   logic [GEN_BITS-1:0]     gen_ff [WORKER_LIMIT];
   logic [GEN_BITS-1:0]     gen_in [WORKER_LIMIT];
   logic [3:0]              aw_ff, aw_in;
   logic [CW-1:0]           pend_ff, pend_in;
   logic [3:0]              state_ff, state_in;
   logic [SW-1:0]           slot_ff, slot_in;
   logic [WW-1:0]           wk_ff, wk_in;
   logic [CW-1:0]           idx_ff, idx_in, keep_ff, keep_in;
   logic [6:0]              cnt_ff, cnt_in;
   logic                    sweep_ff, sweep_in;
   logic                    acc_ff, acc_in;
   rsp_type                 out_ff, out_in;
   logic                    out_v_ff, out_v_in;
   rsp_type                 hold_ff, hold_in;     // newest release, not yet sent
   logic                    hold_v_ff, hold_v_in;

   // registered memory reads
   logic [SW-1:0]       order_rd;
   logic [31:0]         handle_rd;
   logic [7:0]          kind_rd;
   logic [GEN_BITS-1:0] snap_rd;
   logic                snap_rd_v, snap_rd_last;
   logic [GEN_BITS-1:0] cur_gen_d;

   logic [SW-1:0] order_addr;
   logic [SW-1:0] kv_addr;
   logic          snap_we, snap_re;
   logic [AW-1:0] snap_addr;
   logic          order_we;
   logic [SW-1:0] order_wa, order_wd;

   // lowest free slot
   logic [SW-1:0] free_slot;
   always_comb begin
      free_slot = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) free_slot = SW'(i);
      end
   end

   // effective worker count
   logic [WCW-1:0] nw;
   always_comb begin
      if (aw_ff == 4'd0) nw = WCW'(1);
      else if (32'(aw_ff) > WORKER_LIMIT) nw = WCW'(WORKER_LIMIT);
      else nw = WCW'(aw_ff);
   end

   logic out_free;
   logic req_fire;
   logic retire_ok;
   assign out_free  = !out_v_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign retire_ok = (req.data.op == OP_RETIRE) && (req.data.handle != 32'd0)
                      && (32'(pend_ff) < TABLE_DEPTH);
   assign csr_ready = 1'b1;

   logic chk_done, chk_safe, chk_start;

   edrt_safe_check #(.GEN_BITS(GEN_BITS)) u_chk (
      .clock(clock), .reset(reset), .start(chk_start),
      .snap_valid(snap_rd_v), .snap_last(snap_rd_last),
      .snap_value(snap_rd), .cur_value(cur_gen_d),
      .done(chk_done), .safe(chk_safe)
   );

   assign chk_start = (state_ff == S_SRD);
   assign snap_addr = AW'(32'(slot_ff) * WORKER_LIMIT + 32'(wk_ff));
   assign snap_we   = (state_ff == S_SNAP);
   assign snap_re   = (state_ff == S_SCMP);
   // sweep walks oldest first, drain newest first
   assign order_addr = sweep_ff ? SW'(idx_ff) : SW'(idx_ff - CW'(1));
   assign kv_addr   = slot_ff;
   assign order_we  = ((state_ff == S_SNAP) && (32'(wk_ff) == WORKER_LIMIT - 1))
                    || ((state_ff == S_SDEC) && !chk_safe);
   assign order_wa  = (state_ff == S_SNAP) ? SW'(pend_ff) : SW'(keep_ff);
   assign order_wd  = slot_ff;

   always_ff @(posedge clock) begin
      if (snap_we) snap_mem[snap_addr] <= gen_ff[wk_ff];
      snap_rd <= snap_mem[snap_addr];
      if (order_we) order_mem[order_wa] <= order_wd;
      order_rd <= order_mem[order_addr];
      if (req_fire && retire_ok) begin
         handle_mem[free_slot] <= req.data.handle;
         kind_mem[free_slot]   <= req.data.release_kind;
      end
      handle_rd <= handle_mem[kv_addr];
      kind_rd   <= kind_mem[kv_addr];
      cur_gen_d <= gen_ff[wk_ff];
      snap_rd_last <= (32'(wk_ff) + 1 >= 32'(nw));
   end

   always_ff @(posedge clock) begin
      if (reset) snap_rd_v <= 1'b0;
      else snap_rd_v <= snap_re;
   end

   always_comb begin
      aw_in     = csr_valid ? csr_data : aw_ff;
      in_use_in = in_use_ff;
      gen_in    = gen_ff;
      pend_in   = pend_ff;
      state_in  = state_ff;
      slot_in   = slot_ff;
      wk_in     = wk_ff;
      idx_in    = idx_ff;
      keep_in   = keep_ff;
      cnt_in    = cnt_ff;
      sweep_in  = sweep_ff;
      acc_in    = acc_ff;
      out_in    = out_ff;
      out_v_in  = out_v_ff && !rsp.ready;
      hold_in   = hold_ff;
      hold_v_in = hold_v_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cnt_in    = '0;
               idx_in    = '0;
               keep_in   = '0;
               wk_in     = '0;
               slot_in   = free_slot;
               acc_in    = 1'b0;
               hold_v_in = 1'b0;
               case (req.data.op)
                  OP_RETIRE: begin
                     if (retire_ok) begin
                        acc_in = 1'b1;
                        in_use_in[free_slot] = 1'b1;
                        state_in = S_SNAP;
                     end else state_in = S_OUT;
                  end
                  OP_SETGEN: begin
                     if (32'(req.data.worker_index) < WORKER_LIMIT)
                        gen_in[WW'(req.data.worker_index)] =
                           GEN_BITS'(req.data.generation);
                     state_in = S_OUT;
                  end
                  OP_SWEEP: begin
                     sweep_in = 1'b1;
                     state_in = (pend_ff == '0) ? S_FIN : S_SRD;
                  end
                  default: begin
                     sweep_in = 1'b0;
                     idx_in   = pend_ff;
                     state_in = (pend_ff == '0) ? S_FIN : S_DRD;
                  end
               endcase
            end
         end
         S_SNAP: begin
            if (32'(wk_ff) == WORKER_LIMIT - 1) begin
               pend_in  = pend_ff + CW'(1);
               state_in = S_OUT;
            end else wk_in = wk_ff + WW'(1);
         end
         S_OUT: begin
            if (out_free) begin
               out_in          = '0;
               out_in.accepted = acc_ff;
               out_in.last     = 1'b1;
               out_v_in        = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_SRD: begin
            wk_in    = '0;
            state_in = S_SLOT;
         end
         S_SLOT: begin
            slot_in  = order_rd;
            state_in = sweep_ff ? S_SCMP : S_DREL;
         end
         S_SCMP: begin
            if (32'(wk_ff) + 1 >= 32'(nw)) state_in = S_SWAIT;
            else wk_in = wk_ff + WW'(1);
         end
         S_SWAIT: if (chk_done) state_in = S_SDEC;
         S_SDEC: begin
            if (chk_safe) state_in = S_DREL;
            else begin
               keep_in  = keep_ff + CW'(1);
               idx_in   = idx_ff + CW'(1);
               state_in = (idx_ff + CW'(1) >= pend_ff) ? S_FIN : S_SRD;
            end
         end
         S_DRD: state_in = S_SLOT;
         S_DREL: state_in = S_DEMIT;
         S_DEMIT: begin
            // the held release goes out once a newer one takes its place
            if (!hold_v_ff || out_free) begin
               if (hold_v_ff) begin
                  out_in   = hold_ff;
                  out_v_in = 1'b1;
               end
               hold_in                 = '0;
               hold_in.released_valid  = 1'b1;
               hold_in.released_handle = handle_rd;
               hold_in.released_kind   = kind_rd;
               hold_v_in               = 1'b1;
               in_use_in[slot_ff]      = 1'b0;
               cnt_in                  = cnt_ff + 7'd1;
               if (sweep_ff) begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = (idx_ff + CW'(1) >= pend_ff) ? S_FIN : S_SRD;
               end else begin
                  idx_in   = idx_ff - CW'(1);
                  state_in = (idx_ff == CW'(1)) ? S_FIN : S_DRD;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               if (hold_v_ff) begin
                  out_in = hold_ff;
                  out_in.reclaimed_count = cnt_ff[5:0];
               end else out_in = '0;
               out_in.last = 1'b1;
               out_v_in    = 1'b1;
               hold_v_in   = 1'b0;
               pend_in     = sweep_ff ? keep_ff : '0;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aw_ff     <= 4'd1;
         in_use_ff <= '0;
         pend_ff   <= '0;
         state_ff  <= S_IDLE;
         out_v_ff  <= 1'b0;
         hold_v_ff <= 1'b0;
         for (int w = 0; w < WORKER_LIMIT; w++) gen_ff[w] <= '0;
      end else begin
         aw_ff     <= aw_in;
         in_use_ff <= in_use_in;
         pend_ff   <= pend_in;
         state_ff  <= state_in;
         out_v_ff  <= out_v_in;
         hold_v_ff <= hold_v_in;
         gen_ff    <= gen_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      wk_ff    <= wk_in;
      idx_ff   <= idx_in;
      keep_ff  <= keep_in;
      cnt_ff   <= cnt_in;
      sweep_ff <= sweep_in;
      acc_ff   <= acc_in;
      out_ff   <= out_in;
      hold_ff  <= hold_in;
   end

   assign rsp.valid = out_v_ff;
   assign rsp.data  = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      32'(pend_ff) <= TABLE_DEPTH) else $error("pending overflow");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("ready while busy");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> ((cnt_ff != '0) == hold_v_ff))
      else $error("held release out of step with count");
endmodule
